/* design/srt_pkg.sv */
// ----------------------------------------------------------------------------
// srt_pkg
// Shared types and codes for the subresource region tracker.
// ----------------------------------------------------------------------------
package srt_pkg;

   typedef enum logic [1:0] {
      CMD_APPLY  = 2'd0,
      CMD_LOOKUP = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_UNUSED = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_INVALID   = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_START,
      OP_READ,
      OP_P1_EVAL,
      OP_RESTART,
      OP_P2_EVAL,
      OP_NEXT,
      OP_FRAG,
      OP_COMMIT,
      OP_LK_HIT,
      OP_CLEAR
   } dp_op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_P1_RD,
      S_P1_EV,
      S_FULLCHK,
      S_P2_RD,
      S_P2_EV,
      S_P2_FR,
      S_CHG,
      S_LK_RD,
      S_LK_EV,
      S_FIN
   } ctrl_state_type;

   typedef struct packed {
      logic [2:0]  aspect;
      logic [10:0] layer0;
      logic [11:0] layers;
      logic [3:0]  level0;
      logic [4:0]  levels;
   } rect_type;

   typedef struct packed {
      rect_type    r;
      logic [31:0] layout;
   } entry_type;

   typedef struct packed {
      dp_op_type  op;
      logic       rsp_load;
      status_type rsp_status;
   } dp_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    chg_bad;
      logic    walk_done;
      logic    full;
      logic    fmask_zero;
      logic    lk_hit;
      logic    rsp_free;
   } dp_stat_type;

endpackage

/* design/subresource_region_tracker.sv */
// ----------------------------------------------------------------------------
// subresource_region_tracker
// Layout table of non-overlapping subresource rectangles with apply,
// lookup and clear commands.
// ----------------------------------------------------------------------------
//  channel   ports            direction  flow
//  request   req_*            in         valid / stall
//  response  rsp_*            out        valid / stall
//
//  Apply makes a count pass, which copies the entries it keeps and counts
//  fragments, then a build pass that writes the fragments and the new
//  entry; an overflowing apply stops after the count pass. Lookup walks
//  the entries until one covers the query's base layer and level.
//  Reset empties the table at once; no sweep. A stalled response holds the
//  next one back; a new request is taken while the previous response waits.
// ----------------------------------------------------------------------------
module subresource_region_tracker #(
   parameter int TABLE_DEPTH = 64,
   parameter int MAX_LAYERS  = 2048,
   parameter int MAX_LEVELS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [2:0]  req_aspect_mask,
   input  logic [10:0] req_base_layer,
   input  logic [11:0] req_layer_count,
   input  logic [3:0]  req_base_level,
   input  logic [4:0]  req_level_count,
   input  logic [31:0] req_layout_tag,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_found_layout,
   output logic [6:0]  rsp_entry_count
);

   srt_pkg::dp_cmd_type  cmd;
   srt_pkg::dp_stat_type stat;

   srt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   srt_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .MAX_LAYERS  (MAX_LAYERS),
      .MAX_LEVELS  (MAX_LEVELS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_cmd          (req_cmd),
      .req_aspect_mask  (req_aspect_mask),
      .req_base_layer   (req_base_layer),
      .req_layer_count  (req_layer_count),
      .req_base_level   (req_base_level),
      .req_level_count  (req_level_count),
      .req_layout_tag   (req_layout_tag),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_found_layout (rsp_found_layout),
      .rsp_entry_count  (rsp_entry_count)
   );

endmodule

/* design/srt_ctrl.sv */
// ----------------------------------------------------------------------------
// srt_ctrl
// Command sequencer: table walks for apply (two passes) and lookup.
// ----------------------------------------------------------------------------
module srt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  srt_pkg::dp_stat_type stat,
   output srt_pkg::dp_cmd_type  cmd
);

   srt_pkg::ctrl_state_type state_ff, state_in;
   srt_pkg::status_type     st_ff, st_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srt_pkg::S_IDLE;
         st_ff    <= srt_pkg::ST_OK;
      end else begin
         state_ff <= state_in;
         st_ff    <= st_in;
      end
   end

   assign req_stall = (state_ff != srt_pkg::S_IDLE);

   always_comb begin
      state_in       = state_ff;
      st_in          = st_ff;
      cmd.op         = srt_pkg::OP_NONE;
      cmd.rsp_load   = 1'b0;
      cmd.rsp_status = st_ff;
      unique case (state_ff)
         srt_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.op   = srt_pkg::OP_LOAD;
               state_in = srt_pkg::S_DECODE;
            end
         end
         srt_pkg::S_DECODE: begin
            cmd.op = srt_pkg::OP_START;
            unique case (stat.cmd)
               srt_pkg::CMD_APPLY: begin
                  if (stat.chg_bad) begin
                     st_in    = srt_pkg::ST_INVALID;
                     state_in = srt_pkg::S_FIN;
                  end else begin
                     state_in = srt_pkg::S_P1_RD;
                  end
               end
               srt_pkg::CMD_LOOKUP: state_in = srt_pkg::S_LK_RD;
               srt_pkg::CMD_CLEAR: begin
                  cmd.op   = srt_pkg::OP_CLEAR;
                  st_in    = srt_pkg::ST_OK;
                  state_in = srt_pkg::S_FIN;
               end
               default: begin
                  st_in    = srt_pkg::ST_INVALID;
                  state_in = srt_pkg::S_FIN;
               end
            endcase
         end
         srt_pkg::S_P1_RD: begin
            if (stat.walk_done) begin
               state_in = srt_pkg::S_FULLCHK;
            end else begin
               cmd.op   = srt_pkg::OP_READ;
               state_in = srt_pkg::S_P1_EV;
            end
         end
         srt_pkg::S_P1_EV: begin
            cmd.op   = srt_pkg::OP_P1_EVAL;
            state_in = srt_pkg::S_P1_RD;
         end
         srt_pkg::S_FULLCHK: begin
            if (stat.full) begin
               st_in    = srt_pkg::ST_FULL;
               state_in = srt_pkg::S_FIN;
            end else begin
               cmd.op   = srt_pkg::OP_RESTART;
               state_in = srt_pkg::S_P2_RD;
            end
         end
         srt_pkg::S_P2_RD: begin
            if (stat.walk_done) begin
               state_in = srt_pkg::S_CHG;
            end else begin
               cmd.op   = srt_pkg::OP_READ;
               state_in = srt_pkg::S_P2_EV;
            end
         end
         srt_pkg::S_P2_EV: begin
            cmd.op   = srt_pkg::OP_P2_EVAL;
            state_in = srt_pkg::S_P2_FR;
         end
         srt_pkg::S_P2_FR: begin
            if (stat.fmask_zero) begin
               cmd.op   = srt_pkg::OP_NEXT;
               state_in = srt_pkg::S_P2_RD;
            end else begin
               cmd.op = srt_pkg::OP_FRAG;
            end
         end
         srt_pkg::S_CHG: begin
            cmd.op   = srt_pkg::OP_COMMIT;
            st_in    = srt_pkg::ST_OK;
            state_in = srt_pkg::S_FIN;
         end
         srt_pkg::S_LK_RD: begin
            if (stat.walk_done) begin
               st_in    = srt_pkg::ST_NOT_FOUND;
               state_in = srt_pkg::S_FIN;
            end else begin
               cmd.op   = srt_pkg::OP_READ;
               state_in = srt_pkg::S_LK_EV;
            end
         end
         srt_pkg::S_LK_EV: begin
            if (stat.lk_hit) begin
               cmd.op   = srt_pkg::OP_LK_HIT;
               st_in    = srt_pkg::ST_OK;
               state_in = srt_pkg::S_FIN;
            end else begin
               cmd.op   = srt_pkg::OP_NEXT;
               state_in = srt_pkg::S_LK_RD;
            end
         end
         srt_pkg::S_FIN: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = srt_pkg::S_IDLE;
            end
         end
         default: state_in = srt_pkg::S_IDLE;
      endcase
   end

endmodule

/* design/srt_datapath.sv */
// ----------------------------------------------------------------------------
// srt_datapath
// Double-banked region table, overlap/fragment logic and response register.
// ----------------------------------------------------------------------------
module srt_datapath #(
   parameter int TABLE_DEPTH = 64,
   parameter int MAX_LAYERS  = 2048,
   parameter int MAX_LEVELS  = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  srt_pkg::dp_cmd_type  cmd,
   output srt_pkg::dp_stat_type stat,
   input  logic [1:0]           req_cmd,
   input  logic [2:0]           req_aspect_mask,
   input  logic [10:0]          req_base_layer,
   input  logic [11:0]          req_layer_count,
   input  logic [3:0]           req_base_level,
   input  logic [4:0]           req_level_count,
   input  logic [31:0]          req_layout_tag,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_status,
   output logic [31:0]          rsp_found_layout,
   output logic [6:0]           rsp_entry_count
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int FW = CW + 2;
   localparam int TW = FW + 1;
   localparam int MD = 2 ** (IW + 1);

   srt_pkg::entry_type mem [MD];

   srt_pkg::cmd_type   cmd_ff;
   srt_pkg::rect_type  q_ff;
   logic [31:0]        tag_ff;
   logic               bank_ff;
   logic [CW-1:0]      count_ff, idx_ff, wptr_ff;
   logic [FW-1:0]      nfrag_ff;
   srt_pkg::entry_type rd_ff;
   logic [3:0]         fmask_ff;
   logic [31:0]        found_ff;
   logic               rsp_valid_ff;
   logic [1:0]         rsp_status_ff;
   logic [31:0]        rsp_found_ff;
   logic [6:0]         rsp_count_ff;

   srt_pkg::rect_type  s, fr0, fr1, fr2, fr3, frag, strip;
   logic [2:0]         common;
   logic [12:0]        c_le, s_le, le, le_m_ls, sle_m_le;
   logic [5:0]         c_ve, s_ve, ve, sve_m_ve;
   logic [10:0]        ls;
   logic [3:0]         vs;
   logic               ovl;
   logic [3:0]         conds;
   logic [FW-1:0]      nadd;
   logic [TW-1:0]      total;
   logic               we;
   srt_pkg::entry_type wdata;
   logic [IW:0]        waddr, raddr;

   assign s      = rd_ff.r;
   assign common = s.aspect & q_ff.aspect;
   assign c_le   = {1'b0, q_ff.layers} + {2'b0, q_ff.layer0};
   assign c_ve   = {1'b0, q_ff.levels} + {2'b0, q_ff.level0};
   assign s_le   = {1'b0, s.layers} + {2'b0, s.layer0};
   assign s_ve   = {1'b0, s.levels} + {2'b0, s.level0};
   assign ls     = (s.layer0 > q_ff.layer0) ? s.layer0 : q_ff.layer0;
   assign vs     = (s.level0 > q_ff.level0) ? s.level0 : q_ff.level0;
   assign le     = (s_le < c_le) ? s_le : c_le;
   assign ve     = (s_ve < c_ve) ? s_ve : c_ve;
   assign ovl    = (common != 3'd0) && (le > {2'b0, ls}) && (ve > {2'b0, vs});
   assign conds  = {s_ve > c_ve, s.level0 < q_ff.level0,
                    s_le > c_le, s.layer0 < q_ff.layer0};
   assign le_m_ls  = le - {2'b0, ls};
   assign sle_m_le = s_le - le;
   assign sve_m_ve = s_ve - ve;

   assign fr0 = '{common, s.layer0, {1'b0, ls - s.layer0}, s.level0, s.levels};
   assign fr1 = '{common, le[10:0], sle_m_le[11:0], s.level0, s.levels};
   assign fr2 = '{common, ls, le_m_ls[11:0], s.level0, {1'b0, vs - s.level0}};
   assign fr3 = '{common, ls, le_m_ls[11:0], ve[3:0], sve_m_ve[4:0]};

   always_comb begin
      priority if (fmask_ff[0]) frag = fr0;
      else if (fmask_ff[1]) frag = fr1;
      else if (fmask_ff[2]) frag = fr2;
      else frag = fr3;
   end

   always_comb begin
      strip        = s;
      strip.aspect = s.aspect & ~q_ff.aspect;
   end

   assign nadd  = FW'(conds[0]) + FW'(conds[1]) + FW'(conds[2]) + FW'(conds[3]);
   assign total = TW'(wptr_ff) + TW'(nfrag_ff) + TW'(1);

   always_comb begin
      we    = 1'b0;
      wdata = rd_ff;
      unique case (cmd.op)
         srt_pkg::OP_P1_EVAL: begin
            if (!ovl) begin
               we = 1'b1;
            end else if (s.aspect != q_ff.aspect) begin
               we    = 1'b1;
               wdata = '{strip, rd_ff.layout};
            end
         end
         srt_pkg::OP_FRAG: begin
            we    = 1'b1;
            wdata = '{frag, rd_ff.layout};
         end
         srt_pkg::OP_COMMIT: begin
            we    = 1'b1;
            wdata = '{q_ff, tag_ff};
         end
         default: we = 1'b0;
      endcase
   end

   assign waddr = {~bank_ff, wptr_ff[IW-1:0]};
   assign raddr = {bank_ff, idx_ff[IW-1:0]};

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (cmd.op == srt_pkg::OP_READ) begin
         rd_ff <= mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == srt_pkg::OP_LOAD) begin
         cmd_ff <= srt_pkg::cmd_type'(req_cmd);
         q_ff   <= '{req_aspect_mask, req_base_layer, req_layer_count,
                     req_base_level, req_level_count};
         tag_ff <= req_layout_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff  <= 1'b0;
         count_ff <= '0;
         idx_ff   <= '0;
         wptr_ff  <= '0;
         nfrag_ff <= '0;
         fmask_ff <= '0;
         found_ff <= '0;
      end else begin
         unique case (cmd.op)
            srt_pkg::OP_START: begin
               idx_ff   <= '0;
               wptr_ff  <= '0;
               nfrag_ff <= '0;
               found_ff <= '0;
            end
            srt_pkg::OP_CLEAR: begin
               count_ff <= '0;
               found_ff <= '0;
            end
            srt_pkg::OP_P1_EVAL: begin
               idx_ff <= idx_ff + CW'(1);
               if (we) wptr_ff <= wptr_ff + CW'(1);
               if (ovl) nfrag_ff <= nfrag_ff + nadd;
            end
            srt_pkg::OP_RESTART: idx_ff <= '0;
            srt_pkg::OP_P2_EVAL: fmask_ff <= ovl ? conds : 4'd0;
            srt_pkg::OP_NEXT:    idx_ff <= idx_ff + CW'(1);
            srt_pkg::OP_FRAG: begin
               wptr_ff  <= wptr_ff + CW'(1);
               fmask_ff <= fmask_ff & (fmask_ff - 4'd1);
            end
            srt_pkg::OP_COMMIT: begin
               count_ff <= wptr_ff + CW'(1);
               bank_ff  <= ~bank_ff;
            end
            srt_pkg::OP_LK_HIT: found_ff <= rd_ff.layout;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_found_ff  <= found_ff;
         rsp_count_ff  <= 7'(count_ff);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_found_layout = rsp_found_ff;
   assign rsp_entry_count  = rsp_count_ff;

   assign stat.cmd        = cmd_ff;
   assign stat.chg_bad    = (q_ff.aspect == 3'd0) || (q_ff.layers == 12'd0) ||
                            (q_ff.levels == 5'd0) ||
                            (32'(c_le) > 32'(MAX_LAYERS)) ||
                            (32'(c_ve) > 32'(MAX_LEVELS));
   assign stat.walk_done  = (idx_ff == count_ff);
   assign stat.full       = (total > TW'(TABLE_DEPTH));
   assign stat.fmask_zero = (fmask_ff == 4'd0);
   assign stat.lk_hit     = (common != 3'd0) && (q_ff.layer0 >= s.layer0) &&
                            ({2'b0, q_ff.layer0} < s_le) &&
                            (q_ff.level0 >= s.level0) &&
                            ({2'b0, q_ff.level0} < s_ve);
   assign stat.rsp_free   = !rsp_valid_ff || !rsp_stall;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_commit_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.op == srt_pkg::OP_COMMIT |=> count_ff != '0)
      else $error("commit left an empty table");

   a_frag_pending: assert property (@(posedge clock) disable iff (reset)
      cmd.op == srt_pkg::OP_FRAG |-> fmask_ff != 4'd0)
      else $error("fragment write without pending fragment");

endmodule
